// ===== hdl/dsmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsmc_pkg
// Shared types, constants and round functions for the double SHA-256 unit.
// ----------------------------------------------------------------------------
package dsmc_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] state_t;   // index 0 is a, index 7 is h
    typedef logic [15:0][31:0] block_t;  // index 0 is the first message word

    localparam int unsigned RoundCount = 64;

    // Configuration register indexes.
    localparam logic [1:0] REG_TARGET_0 = 2'd0;
    localparam logic [1:0] REG_TARGET_1 = 2'd1;
    localparam logic [1:0] REG_TARGET_2 = 2'd2;
    localparam logic [1:0] REG_TARGET_3 = 2'd3;

    localparam state_t IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t PAD_WORD  = 32'h80000000;
    localparam word_t LEN_FIRST = 32'd640;
    localparam word_t LEN_SECOND = 32'd256;

    localparam word_t ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t bswap(input word_t x);
        bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // One compression round.
    function automatic state_t sha_round(input state_t v, input word_t k, input word_t w);
        word_t t1;
        word_t t2;
        state_t r;
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        r[7] = v[6];
        r[6] = v[5];
        r[5] = v[4];
        r[4] = v[3] + t1;
        r[3] = v[2];
        r[2] = v[1];
        r[1] = v[0];
        r[0] = t1 + t2;
        sha_round = r;
    endfunction

    // Slide the sixteen-word schedule window by one word.
    function automatic block_t sha_sched(input block_t w);
        word_t s0;
        word_t s1;
        block_t r;
        s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
        s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
        for (int i = 0; i < 15; i++) begin
            r[i] = w[i + 1];
        end
        r[15] = s1 + w[9] + s0 + w[0];
        sha_sched = r;
    endfunction

endpackage

// ===== hdl/dsmc_comp.sv =====
// ----------------------------------------------------------------------------
// dsmc_comp
// Fully unrolled SHA-256 compression, one round per register stage.
// ----------------------------------------------------------------------------
module dsmc_comp (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  dsmc_pkg::state_t in_cv,
    input  dsmc_pkg::block_t in_msg,
    output logic            out_valid,
    output dsmc_pkg::state_t out_cv
);
    import dsmc_pkg::*;

    logic [RoundCount:0] valid_reg;
    state_t v_reg  [0:RoundCount];
    state_t cv_reg [0:RoundCount];
    block_t w_reg  [0:RoundCount];
    logic   out_valid_reg;
    state_t out_cv_reg;
    state_t out_cv_next;

    // Feed-forward add of the chaining value.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            out_cv_next[i] = cv_reg[RoundCount][i] + v_reg[RoundCount][i];
        end
    end

    // Valid bits travel with the words; the whole chain moves on enable.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg     <= {valid_reg[RoundCount-1:0], in_valid};
            out_valid_reg <= valid_reg[RoundCount];
        end
    end

    // Round stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0]  <= in_cv;
            cv_reg[0] <= in_cv;
            w_reg[0]  <= in_msg;
            for (int s = 0; s < RoundCount; s++) begin
                v_reg[s+1]  <= sha_round(v_reg[s], ROUND_K[s], w_reg[s][0]);
                w_reg[s+1]  <= sha_sched(w_reg[s]);
                cv_reg[s+1] <= cv_reg[s];
            end
            out_cv_reg <= out_cv_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cv    = out_cv_reg;

endmodule

// ===== hdl/double_sha256_midstate_check_unit.sv =====
// ----------------------------------------------------------------------------
// double_sha256_midstate_check_unit
// Double SHA-256 of an 80-byte header from midstate and tail, target check.
// ----------------------------------------------------------------------------
// The unit takes one word per cycle and delivers one result word per cycle
// while results are taken. Each word passes two unrolled compressions of 66
// register stages each and a compare stage. The whole pipeline advances
// together; when the result word is not taken, every stage holds and s_ready
// drops.
module double_sha256_midstate_check_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_midstate_0,
    input  logic [63:0] s_midstate_1,
    input  logic [63:0] s_midstate_2,
    input  logic [63:0] s_midstate_3,
    input  logic [63:0] s_tail_0,
    input  logic [63:0] s_tail_1,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_0,
    output logic [63:0] m_hash_1,
    output logic [63:0] m_hash_2,
    output logic [63:0] m_hash_3,
    output logic        m_meets_target
);
    import dsmc_pkg::*;

    logic        en;
    logic [63:0] target_reg [0:3];
    logic [63:0] mid [0:3];
    state_t      cv_first;
    block_t      msg_first;
    logic        v1;
    state_t      d1;
    block_t      msg_second;
    logic        v2;
    state_t      d2;
    logic [255:0] hash_num;
    logic [255:0] target_num;
    logic [255:0] hash_flat;
    logic [255:0] target_flat;
    logic        m_valid_reg;
    logic [255:0] hash_reg;
    logic        meets_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Target registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                target_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TARGET_0: target_reg[0] <= cfg_data;
                REG_TARGET_1: target_reg[1] <= cfg_data;
                REG_TARGET_2: target_reg[2] <= cfg_data;
                REG_TARGET_3: target_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // First block: midstate words are little-endian, tail plus padding.
    always_comb begin
        mid[0] = s_midstate_0;
        mid[1] = s_midstate_1;
        mid[2] = s_midstate_2;
        mid[3] = s_midstate_3;
        for (int i = 0; i < 4; i++) begin
            cv_first[2*i]   = bswap(mid[i][63:32]);
            cv_first[2*i+1] = bswap(mid[i][31:0]);
        end
        msg_first     = '0;
        msg_first[0]  = s_tail_0[63:32];
        msg_first[1]  = s_tail_0[31:0];
        msg_first[2]  = s_tail_1[63:32];
        msg_first[3]  = s_tail_1[31:0];
        msg_first[4]  = PAD_WORD;
        msg_first[15] = LEN_FIRST;
    end

    dsmc_comp u_first (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_cv    (cv_first),
        .in_msg   (msg_first),
        .out_valid(v1),
        .out_cv   (d1)
    );

    // Second block: the first digest, padded for 32 bytes.
    always_comb begin
        msg_second = '0;
        for (int i = 0; i < 8; i++) begin
            msg_second[i] = d1[i];
        end
        msg_second[8]  = PAD_WORD;
        msg_second[15] = LEN_SECOND;
    end

    dsmc_comp u_second (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v1),
        .in_cv    (IV),
        .in_msg   (msg_second),
        .out_valid(v2),
        .out_cv   (d2)
    );

    // Compare as 256-bit numbers with byte 31 most significant.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            hash_flat[255-32*i -: 32] = d2[i];
        end
        target_flat = {target_reg[0], target_reg[1], target_reg[2], target_reg[3]};
        for (int k = 0; k < 32; k++) begin
            hash_num[8*k +: 8]   = hash_flat[255-8*k -: 8];
            target_num[8*k +: 8] = target_flat[255-8*k -: 8];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hash_reg  <= hash_flat;
            meets_reg <= (hash_num <= target_num);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hash_0       = hash_reg[255:192];
    assign m_hash_1       = hash_reg[191:128];
    assign m_hash_2       = hash_reg[127:64];
    assign m_hash_3       = hash_reg[63:0];
    assign m_meets_target = meets_reg;

    // A held result stays valid and keeps its first hash word and target flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_0) && $stable(m_meets_target))
        else $error("result changed while stalled");

    // Input is refused only while a result waits.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without cause");

    // A write to target register 0 lands in its register.
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && cfg_index == REG_TARGET_0 |=> target_reg[0] == $past(cfg_data))
        else $error("target write lost");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double SHA-256 midstate check unit. Words carry
// a midstate and a header tail; a local model computes the double hash and
// the target compare, and every result word is checked against it in order.
// ----------------------------------------------------------------------------
module testbench;
    import dsmc_pkg::*;

    localparam int PipeDepth  = 133;
    localparam int RandWords  = 1550;
    localparam int IdleLimit  = 20000;

    typedef struct {
        logic [63:0] hash [4];
        logic        meets;
    } digest_t;

    typedef struct {
        logic [63:0] mid [4];
        logic [63:0] tail [2];
        logic        fixed;   // expected hash given by the caller
        logic [63:0] hash [4];
        logic        meets;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_TARGET_0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_midstate_0 = '0, s_midstate_1 = '0, s_midstate_2 = '0;
    logic [63:0] s_midstate_3 = '0, s_tail_0 = '0, s_tail_1 = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_hash_0, m_hash_1, m_hash_2, m_hash_3;
    logic        m_meets_target;

    logic [63:0] target_regs [4];
    digest_t     pending_digests [$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          hold_off_req = 1'b0;
    bit          hold_off_done = 1'b0;
    bit          sending = 1'b1;

    double_sha256_midstate_check_unit DUT (.*);

    always #5 aclk = ~aclk;

    // Rotate right for the local hash model.
    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One compression of sixteen message words into the chaining value.
    function automatic void compress_block(ref logic [31:0] cv [8],
                                           input logic [31:0] msg [16]);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, x, y;
        for (int i = 0; i < 16; i++) w[i] = msg[i];
        for (int i = 16; i < 64; i++) begin
            x = w[i-15];
            y = w[i-2];
            w[i] = (ror(y, 17) ^ ror(y, 19) ^ (y >> 10)) + w[i-7]
                 + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = cv[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) cv[i] += v[i];
    endfunction

    // Double hash of a midstate and tail, then the target compare.
    function automatic digest_t double_hash(logic [63:0] mid [4], logic [63:0] tail [2]);
        logic [31:0] cv [8];
        logic [31:0] msg [16];
        logic [31:0] be;
        logic [255:0] h_num, t_num;
        digest_t d;
        for (int i = 0; i < 8; i++) begin
            be = (i % 2) ? mid[i/2][31:0] : mid[i/2][63:32];
            cv[i] = {be[7:0], be[15:8], be[23:16], be[31:24]};
        end
        for (int i = 0; i < 16; i++) msg[i] = '0;
        msg[0] = tail[0][63:32]; msg[1] = tail[0][31:0];
        msg[2] = tail[1][63:32]; msg[3] = tail[1][31:0];
        msg[4] = 32'h80000000;
        msg[15] = 32'd640;
        compress_block(cv, msg);
        for (int i = 0; i < 16; i++) msg[i] = '0;
        for (int i = 0; i < 8; i++) msg[i] = cv[i];
        msg[8] = 32'h80000000;
        msg[15] = 32'd256;
        for (int i = 0; i < 8; i++) cv[i] = IV[i];
        compress_block(cv, msg);
        for (int i = 0; i < 4; i++) d.hash[i] = {cv[2*i], cv[2*i+1]};
        // Byte 31 is most significant; byte k sits in field k/8.
        for (int k = 0; k < 32; k++) begin
            h_num[8*k +: 8] = d.hash[k/8][56 - 8*(k%8) +: 8];
            t_num[8*k +: 8] = target_regs[k/8][56 - 8*(k%8) +: 8];
        end
        d.meets = (h_num <= t_num);
        return d;
    endfunction

    // Register write while the unit is idle; the local copy follows.
    // The write enable drops only after the last write of a burst.
    task automatic write_target(logic [1:0] idx, logic [63:0] value, bit last);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        target_regs[idx] = value;
        @(posedge aclk);
        if (last) cfg_we <= 1'b0;
    endtask

    task automatic write_all_targets(logic [63:0] v0, logic [63:0] v1,
                                     logic [63:0] v2, logic [63:0] v3);
        write_target(REG_TARGET_0, v0, 1'b0);
        write_target(REG_TARGET_1, v1, 1'b0);
        write_target(REG_TARGET_2, v2, 1'b0);
        write_target(REG_TARGET_3, v3, 1'b1);
    endtask

    function automatic int gap_length();
        if ($urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Offer one word and wait for it to be taken; queue its expected result.
    task automatic send_word(logic [63:0] mid [4], logic [63:0] tail [2],
                             bit fixed, logic [63:0] hash [4], logic meets);
        digest_t d;
        d = double_hash(mid, tail);
        if (fixed) begin
            d.hash = hash;
            d.meets = meets;
        end
        s_midstate_0 <= mid[0]; s_midstate_1 <= mid[1];
        s_midstate_2 <= mid[2]; s_midstate_3 <= mid[3];
        s_tail_0 <= tail[0]; s_tail_1 <= tail[1];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_digests.push_back(d);
    endtask

    task automatic send_with_gap(logic [63:0] mid [4], logic [63:0] tail [2]);
        logic [63:0] none [4];
        int gap;
        send_word(mid, tail, 1'b0, none, 1'b0);
        gap = gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_digests.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Directed table: extreme and patterned inputs.
    row_t rows [$];

    task automatic add_row(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2,
                           logic [63:0] m3, logic [63:0] t0, logic [63:0] t1);
        row_t r;
        r.mid = '{m0, m1, m2, m3};
        r.tail = '{t0, t1};
        r.fixed = 1'b0;
        r.hash = '{default: '0};
        r.meets = 1'b0;
        rows.push_back(r);
    endtask

    // Result checker.
    always @(posedge aclk) begin
        digest_t d;
        logic [63:0] got [4];
        if (aresetn && m_valid && m_ready) begin
            got = '{m_hash_0, m_hash_1, m_hash_2, m_hash_3};
            if (pending_digests.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word hash_0=%h", m_hash_0);
            end else begin
                d = pending_digests.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== d.hash[i]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("hash_%0d expected %h got %h", i, d.hash[i], got[i]);
                    end
                end
                if (m_meets_target !== d.meets) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("meets_target expected %b got %b", d.meets, m_meets_target);
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off_done = 1'b1;
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            gap = gap_length();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else if (idle_cycles >= IdleLimit) begin
            $display("simulation failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus sequence.
    initial begin
        logic [63:0] mid [4];
        logic [63:0] tail [2];
        digest_t ref_d;
        for (int i = 0; i < 4; i++) target_regs[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase 1: zero target after reset; no ordinary hash meets it.
        add_row('0, '0, '0, '0, '0, '0);
        add_row('1, '1, '1, '1, '1, '1);
        add_row('1, '0, '1, '0, '0, '1);
        add_row(64'h0123456789abcdef, 64'hfedcba9876543210, 64'h55aa55aa55aa55aa,
                64'haa55aa55aa55aa55, 64'h8000000000000001, 64'h7fffffffffffffff);
        foreach (rows[i]) begin
            send_word(rows[i].mid, rows[i].tail, 1'b0, rows[i].hash, rows[i].meets);
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        drain();

        // Phase 2: all-ones target; every hash meets it.
        write_all_targets('1, '1, '1, '1);
        foreach (rows[i]) send_word(rows[i].mid, rows[i].tail, 1'b0, rows[i].hash, 1'b0);
        drain();

        // Phase 3: target equal to a known hash, then two targets altered from it.
        mid = rows[3].mid;
        tail = rows[3].tail;
        ref_d = double_hash(mid, tail);
        write_all_targets(ref_d.hash[0], ref_d.hash[1], ref_d.hash[2], ref_d.hash[3]);
        send_word(mid, tail, 1'b1, ref_d.hash, 1'b1);
        drain();
        write_target(REG_TARGET_0, ref_d.hash[0] - 64'd1, 1'b1);
        send_word(mid, tail, 1'b0, ref_d.hash, 1'b0);
        drain();
        write_target(REG_TARGET_0, ref_d.hash[0], 1'b0);
        write_target(REG_TARGET_3, ref_d.hash[3] ^ 64'h0000000000000100, 1'b1);
        send_word(mid, tail, 1'b0, ref_d.hash, 1'b0);
        drain();

        // Random part in phases with fixed, random and all-zero targets.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_all_targets('1, '1, '1, 64'h00000000ffffffff);
                1: write_all_targets(rand64(), rand64(), rand64(), {$urandom, $urandom});
                2: write_all_targets('1, '1, '1, 64'h7fffffffffffffff);
                3: write_all_targets('0, '0, '0, '0);
                default: write_all_targets(rand64(), rand64(), rand64(), rand64());
            endcase
            if (phase == 1) hold_off_req = 1'b1;
            for (int n = 0; n < RandWords / 5; n++) begin
                for (int i = 0; i < 4; i++) mid[i] = rand64();
                tail = '{rand64(), rand64()};
                send_with_gap(mid, tail);
            end
            // Sender pauses until every result is back.
            drain();
        end

        s_valid <= 1'b0;
        while (pending_digests.size() != 0) @(posedge aclk);
        repeat (PipeDepth + 20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
